[rtl/core/tcp_handshake_rtt_table_core_assert.svh]
// Assertion macros shared by the checker of the handshake round-trip table.
`ifndef TCP_HANDSHAKE_RTT_TABLE_CORE_ASSERT_SVH
`define TCP_HANDSHAKE_RTT_TABLE_CORE_ASSERT_SVH
// Immediate-consequence check, clocked on clk and held off during reset.
`define TCPR_ASSERT_NOW(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
	else $error("tcpr check failed");
// Next-cycle check, clocked on clk and held off during reset.
`define TCPR_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error("tcpr check failed");
`endif

[rtl/core/tcpr_pkg.sv]
// Types and constants of the TCP handshake round-trip table.
package tcpr_pkg;
	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int STAMP_W = 52;
	localparam int TOTAL_W = 56;
	localparam int ROUNDS_W = 32;
	localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

	typedef enum logic [2:0] {
		EV_IGNORED          = 3'd0,
		EV_SYN_NEW          = 3'd1,
		EV_SYN_REARM        = 3'd2,
		EV_MEASURED         = 3'd3,
		EV_SYNACK_UNMATCHED = 3'd4,
		EV_TABLE_FULL       = 3'd5
	} event_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SEL,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic [63:0]         key;
		logic                armed;
		logic [31:0]         seq;
		logic [STAMP_W-1:0]  stamp;
		logic [TOTAL_W-1:0]  total;
		logic [ROUNDS_W-1:0] rounds;
	} rec_t;

	typedef struct packed {
		logic        look;
		logic        upd;
		logic        alloc;
		logic [63:0] key;
	} cell_ctl_t;
endpackage

[rtl/core/tcpr_pkt_if.sv]
// Packet descriptor channel.
interface tcpr_pkt_if;
	logic        valid;
	logic        ready;
	logic        ipv4_tcp;
	logic [31:0] source_addr;
	logic [31:0] dest_addr;
	logic        syn_flag;
	logic        ack_flag;
	logic [31:0] sequence_number;
	logic [31:0] ack_number;
	logic [31:0] stamp_sec;
	logic [19:0] stamp_usec;

	modport source (output valid, ipv4_tcp, source_addr, dest_addr, syn_flag, ack_flag,
		sequence_number, ack_number, stamp_sec, stamp_usec, input ready);
	modport sink (input valid, ipv4_tcp, source_addr, dest_addr, syn_flag, ack_flag,
		sequence_number, ack_number, stamp_sec, stamp_usec, output ready);
endinterface

[rtl/core/tcpr_res_if.sv]
// Result channel.
interface tcpr_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [5:0]  slot;
	logic [51:0] sample_usec;
	logic [55:0] total_usec;
	logic [31:0] handshakes;

	modport source (output valid, event_res, slot, sample_usec, total_usec, handshakes,
		input ready);
	modport sink (input valid, event_res, slot, sample_usec, total_usec, handshakes,
		output ready);
endinterface

[rtl/core/tcp_handshake_rtt_table_core.sv]
// Channel | Dir | Carries
// pkt     | in  | parsed packet descriptor (flags, addresses, numbers, stamp)
// res     | out | event code, slot, sample and the entry's running totals
// Each packet passes through capture and stamp multiply, key match in every cell,
// selection of the hit record with the delta, then the table update and result.
// A new packet is taken only when the previous one has reached the output register.
// Reset clears the cell valid bits, the fill count and the control state at once.
// A stalled result holds the update stage until the output register frees.
module tcp_handshake_rtt_table_core import tcpr_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	tcpr_pkt_if.sink   pkt,
	tcpr_res_if.source res
);
	state_t state_q, state_d;

	logic        tcp_s1, syn_s1, ack_s1;
	logic [63:0] key_s1;
	logic [31:0] seq_s1, ackn_s1;
	logic [19:0] usec_s1;
	logic [STAMP_W-1:0] prod_s1;
	logic [STAMP_W-1:0] now_s2;
	logic               found_s3, seqok_s3;
	logic [IDX_W-1:0]   idx_s3;
	rec_t               rec_s3;
	logic [STAMP_W-1:0] sample_s3;
	logic [CNT_W-1:0]   used_q;

	logic       res_valid_q;
	event_t     ev_q;
	logic [5:0] slot_q;
	logic [51:0] sample_q;
	logic [55:0] total_q;
	logic [31:0] rounds_q;

	logic [TABLE_ENTRIES-1:0] cell_valid, cell_hit;
	rec_t      cell_rec [TABLE_ENTRIES];
	cell_ctl_t ctl;
	rec_t      wr_rec;

	logic             found_c;
	logic [IDX_W-1:0] idx_c;
	rec_t             rec_c;

	logic    commit;
	event_t  ev_c;
	logic [IDX_W-1:0] idx_w;
	logic    has_entry;
	logic [TOTAL_W:0] sum_c;
	logic [TOTAL_W-1:0] total_new;
	logic [ROUNDS_W-1:0] rounds_new;
	logic [STAMP_W-1:0]  sample_c;
	logic    full_c;

	assign pkt.ready = (state_q == ST_IDLE);
	assign commit = (state_q == ST_UPD) && (!res_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (pkt.valid) state_d = ST_LOOK;
			ST_LOOK: state_d = ST_SEL;
			ST_SEL:  state_d = ST_UPD;
			ST_UPD:  if (commit) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Capture stage; a SYN-ACK looks up the reversed pair.
	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			tcp_s1  <= pkt.ipv4_tcp;
			syn_s1  <= pkt.syn_flag;
			ack_s1  <= pkt.ack_flag;
			key_s1  <= pkt.ack_flag ? {pkt.dest_addr, pkt.source_addr}
			                        : {pkt.source_addr, pkt.dest_addr};
			seq_s1  <= pkt.sequence_number;
			ackn_s1 <= pkt.ack_number;
			usec_s1 <= pkt.stamp_usec;
			prod_s1 <= STAMP_W'(pkt.stamp_sec) * STAMP_W'(USEC_PER_SEC);
		end
		if (state_q == ST_LOOK) now_s2 <= prod_s1 + STAMP_W'(usec_s1);
		if (state_q == ST_SEL) begin
			found_s3  <= found_c;
			idx_s3    <= idx_c;
			rec_s3    <= rec_c;
			seqok_s3  <= (rec_c.seq + 32'd1) == ackn_s1;
			sample_s3 <= (now_s2 > rec_c.stamp) ? (now_s2 - rec_c.stamp) : '0;
		end
	end

	// Keys are unique, so at most one cell hits and an OR merge selects it.
	always_comb begin
		found_c = 1'b0;
		idx_c   = '0;
		rec_c   = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (cell_hit[i]) begin
				found_c = 1'b1;
				idx_c   = idx_c | IDX_W'(i);
				rec_c   = rec_c | cell_rec[i];
			end
		end
	end

	always_comb begin
		full_c    = (used_q == CNT_W'(TABLE_ENTRIES));
		sum_c     = {1'b0, rec_s3.total} + (TOTAL_W+1)'(sample_s3);
		total_new = sum_c[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_c[TOTAL_W-1:0];
		rounds_new = (&rec_s3.rounds) ? rec_s3.rounds : rec_s3.rounds + 1'b1;
		ev_c      = EV_IGNORED;
		idx_w     = idx_s3;
		has_entry = 1'b0;
		sample_c  = '0;
		wr_rec    = rec_s3;
		ctl.look  = (state_q == ST_LOOK);
		ctl.key   = key_s1;
		ctl.upd   = 1'b0;
		ctl.alloc = 1'b0;
		priority if (!tcp_s1 || !syn_s1) begin
			ev_c = EV_IGNORED;
		end else if (!ack_s1) begin
			wr_rec.key   = key_s1;
			wr_rec.armed = 1'b1;
			wr_rec.seq   = seq_s1;
			wr_rec.stamp = now_s2;
			if (found_s3) begin
				ev_c      = EV_SYN_REARM;
				has_entry = 1'b1;
				ctl.upd   = commit;
			end else if (full_c) begin
				ev_c = EV_TABLE_FULL;
			end else begin
				ev_c          = EV_SYN_NEW;
				idx_w         = IDX_W'(used_q);
				has_entry     = 1'b1;
				wr_rec.total  = '0;
				wr_rec.rounds = '0;
				ctl.alloc     = commit;
			end
		end else begin
			if (!found_s3) begin
				ev_c = EV_SYNACK_UNMATCHED;
			end else if (!rec_s3.armed || !seqok_s3) begin
				ev_c      = EV_SYNACK_UNMATCHED;
				has_entry = 1'b1;
			end else begin
				ev_c          = EV_MEASURED;
				has_entry     = 1'b1;
				sample_c      = sample_s3;
				wr_rec.armed  = 1'b0;
				wr_rec.total  = total_new;
				wr_rec.rounds = rounds_new;
				ctl.upd       = commit;
			end
		end
	end

	genvar g;
	generate
		for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
			tcpr_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.wr_rec     (wr_rec),
				.prev_valid ((g == 0) ? 1'b1 : cell_valid[(g == 0) ? 0 : g-1]),
				.valid      (cell_valid[g]),
				.hit        (cell_hit[g]),
				.rec        (cell_rec[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (ctl.alloc) used_q <= used_q + 1'b1;
			if (commit) res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			ev_q     <= ev_c;
			slot_q   <= has_entry ? 6'(idx_w) : 6'd0;
			sample_q <= sample_c;
			total_q  <= has_entry ? wr_rec.total : '0;
			rounds_q <= has_entry ? wr_rec.rounds : '0;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.event_res   = ev_q;
	assign res.slot        = slot_q;
	assign res.sample_usec = sample_q;
	assign res.total_usec  = total_q;
	assign res.handshakes  = rounds_q;
endmodule

[rtl/core/tcpr_cell.sv]
// One table entry: stores a record, matches the lookup key and claims itself on allocation.
module tcpr_cell import tcpr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  rec_t      wr_rec,
	input  logic      prev_valid,
	output logic      valid,
	output logic      hit,
	output rec_t      rec
);
	logic valid_q;
	logic hit_q;
	rec_t rec_q;
	logic we;

	// The first unused cell is the one whose left neighbor is already in use.
	assign we = (ctl.upd && hit_q) || (ctl.alloc && prev_valid && !valid_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (we) valid_q <= 1'b1;
			if (ctl.look) hit_q <= valid_q && (rec_q.key == ctl.key);
		end
	end

	always_ff @(posedge clk) begin
		if (we) rec_q <= wr_rec;
	end

	assign valid = valid_q;
	assign hit   = hit_q;
	assign rec   = rec_q;
endmodule

[rtl/core/tcpr_checker.sv]
// Port-level checks of the handshake round-trip table and their binding.
`include "tcp_handshake_rtt_table_core_assert.svh"
module tcpr_checker import tcpr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  event_res,
	input logic [5:0]  slot,
	input logic [51:0] sample_usec,
	input logic [55:0] total_usec,
	input logic [31:0] handshakes
);
	`TCPR_ASSERT_NEXT(a_res_hold, out_valid && !out_ready, out_valid && $stable(event_res) && $stable(total_usec))
	`TCPR_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
	`TCPR_ASSERT_NOW(a_sample_only_measured, out_valid && event_res != EV_MEASURED, sample_usec == 52'd0)
	`TCPR_ASSERT_NOW(a_no_entry_zero, out_valid && (event_res == EV_IGNORED || event_res == EV_TABLE_FULL), slot == 6'd0 && total_usec == 56'd0 && handshakes == 32'd0)
	`TCPR_ASSERT_NOW(a_measured_counts, out_valid && event_res == EV_MEASURED, handshakes != 32'd0)
endmodule

bind tcp_handshake_rtt_table_core tcpr_checker u_tcpr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (pkt.valid),
	.in_ready    (pkt.ready),
	.out_valid   (res.valid),
	.out_ready   (res.ready),
	.event_res   (res.event_res),
	.slot        (res.slot),
	.sample_usec (res.sample_usec),
	.total_usec  (res.total_usec),
	.handshakes  (res.handshakes)
);

[verif/tb_chan_if.sv]
`timescale 1ns / 1ps
// Testbench-side note: the channel interfaces come from the RTL; this file holds shared TB types.
package tb_tcpr_pkg;
	import tcpr_pkg::*;

	typedef struct packed {
		logic        ipv4_tcp;
		logic [31:0] source_addr;
		logic [31:0] dest_addr;
		logic        syn_flag;
		logic        ack_flag;
		logic [31:0] sequence_number;
		logic [31:0] ack_number;
		logic [31:0] stamp_sec;
		logic [19:0] stamp_usec;
	} pkt_item_t;

	typedef struct {
		event_t      ev;
		logic [5:0]  slot;
		logic [51:0] sample_usec;
		logic [55:0] total_usec;
		logic [31:0] handshakes;
	} rtt_result_t;
endpackage

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the TCP handshake round-trip table: directed and random packets.
module tb_top;
	import tcpr_pkg::*;
	import tb_tcpr_pkg::*;

	localparam logic [55:0] TOTAL_SAT = {56{1'b1}};
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	tcpr_pkt_if pkt ();
	tcpr_res_if res ();

	tcp_handshake_rtt_table_core dut (.clk(clk), .arst_n(arst_n), .pkt(pkt), .res(res));

	// Predictor copy of the table.
	logic [63:0] tbl_key [TABLE_ENTRIES];
	logic        tbl_armed [TABLE_ENTRIES];
	logic [31:0] tbl_seq [TABLE_ENTRIES];
	logic [51:0] tbl_stamp [TABLE_ENTRIES];
	logic [55:0] tbl_total [TABLE_ENTRIES];
	logic [31:0] tbl_rounds [TABLE_ENTRIES];
	int          tbl_used;

	pkt_item_t   pending_pkts[$];
	rtt_result_t expected_results[$];
	int          error_count;
	int          cycle_count;
	int          sent_count;
	int          checked_count;
	int          measured_count;
	int          full_count;
	bit          hold_sender;
	// Set after an input transfer so the sender sees it at the falling edge.
	bit          pkt_fire;

	// Known pairs for building well-formed handshakes.
	logic [31:0] pair_src[$];
	logic [31:0] pair_dst[$];

	function automatic void queue_pkt(pkt_item_t p);
		pending_pkts.insert(pending_pkts.size(), p);
	endfunction

	function automatic void add_pair(logic [31:0] s, logic [31:0] d);
		pair_src.insert(pair_src.size(), s);
		pair_dst.insert(pair_dst.size(), d);
	endfunction

	function automatic int find_pair(logic [63:0] key);
		for (int i = 0; i < tbl_used; i++) begin
			if (tbl_key[i] == key) return i;
		end
		return -1;
	endfunction

	function automatic rtt_result_t predict_rtt(pkt_item_t p);
		rtt_result_t r;
		int          idx;
		logic [51:0] now_us;
		logic [56:0] sum;
		r = '{EV_IGNORED, 6'd0, 52'd0, 56'd0, 32'd0};
		if (!p.ipv4_tcp || !p.syn_flag) return r;
		if (!p.ack_flag) begin
			idx = find_pair({p.source_addr, p.dest_addr});
			r.ev = EV_SYN_REARM;
			if (idx < 0) begin
				if (tbl_used >= TABLE_ENTRIES) begin
					r.ev = EV_TABLE_FULL;
					return r;
				end
				idx = tbl_used++;
				tbl_key[idx] = {p.source_addr, p.dest_addr};
				tbl_total[idx] = '0;
				tbl_rounds[idx] = '0;
				r.ev = EV_SYN_NEW;
			end
			tbl_armed[idx] = 1'b1;
			tbl_seq[idx] = p.sequence_number;
			tbl_stamp[idx] = 52'(p.stamp_sec) * 52'd1000000 + 52'(p.stamp_usec);
		end else begin
			idx = find_pair({p.dest_addr, p.source_addr});
			r.ev = EV_SYNACK_UNMATCHED;
			if (idx < 0) return r;
			if (tbl_armed[idx] && tbl_seq[idx] + 32'd1 == p.ack_number) begin
				now_us = 52'(p.stamp_sec) * 52'd1000000 + 52'(p.stamp_usec);
				r.sample_usec = (now_us > tbl_stamp[idx]) ? now_us - tbl_stamp[idx] : '0;
				sum = {1'b0, tbl_total[idx]} + 57'(r.sample_usec);
				tbl_total[idx] = sum[56] ? TOTAL_SAT : sum[55:0];
				if (tbl_rounds[idx] != 32'hFFFF_FFFF) tbl_rounds[idx]++;
				tbl_armed[idx] = 1'b0;
				r.ev = EV_MEASURED;
			end
		end
		r.slot = 6'(idx);
		r.total_usec = tbl_total[idx];
		r.handshakes = tbl_rounds[idx];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("tb_top: mismatch on %s at result %0d: got %0h expected %0h",
			what, checked_count, got, want);
		error_count++;
	endtask

	function automatic pkt_item_t rand_pkt();
		pkt_item_t p;
		p.ipv4_tcp = 1'($urandom);
		p.source_addr = $urandom;
		p.dest_addr = $urandom;
		p.syn_flag = 1'($urandom);
		p.ack_flag = 1'($urandom);
		p.sequence_number = $urandom;
		p.ack_number = $urandom;
		p.stamp_sec = $urandom;
		p.stamp_usec = 20'($urandom);
		return p;
	endfunction

	function automatic pkt_item_t syn_pkt(logic [31:0] s, logic [31:0] d, logic [31:0] sq,
		logic [31:0] sec, logic [19:0] us);
		pkt_item_t p;
		p = '{1'b1, s, d, 1'b1, 1'b0, sq, $urandom, sec, us};
		return p;
	endfunction

	function automatic pkt_item_t synack_pkt(logic [31:0] s, logic [31:0] d, logic [31:0] an,
		logic [31:0] sec, logic [19:0] us);
		pkt_item_t p;
		p = '{1'b1, s, d, 1'b1, 1'b1, $urandom, an, sec, us};
		return p;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sender: bursts of random length separated by random gaps.
	int burst_left;
	int gap_left;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt.valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!pkt.valid || pkt_fire) begin
			if (pkt_fire) begin
				void'(pending_pkts.pop_front());
				sent_count <= sent_count + 1;
			end
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				pkt.valid <= 1'b0;
			end else if (hold_sender || pending_pkts.size() == 0) begin
				pkt.valid <= 1'b0;
			end else begin
				pkt.valid <= 1'b1;
				{pkt.ipv4_tcp, pkt.source_addr, pkt.dest_addr, pkt.syn_flag, pkt.ack_flag,
					pkt.sequence_number, pkt.ack_number, pkt.stamp_sec, pkt.stamp_usec}
					<= pending_pkts[0];
				if (burst_left == 0) begin
					burst_left <= $urandom_range(20, 1);
					gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Receiver: stall pattern from a rotating mask with occasional long stalls.
	logic [15:0] stall_mask;
	int          stall_phase;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			stall_mask <= 16'hFFFF;
			stall_phase <= 0;
		end else begin
			stall_phase <= (stall_phase + 1) % 16;
			if (stall_phase == 15) begin
				case ($urandom_range(3, 0))
					0: stall_mask <= 16'hFFFF;
					1: stall_mask <= 16'($urandom);
					2: stall_mask <= 16'h00FF;
					default: stall_mask <= 16'hAAAA;
				endcase
			end
			res.ready <= stall_mask[stall_phase];
		end
	end

	// Monitor: predict on accepted packets, compare on accepted results.
	always @(posedge clk) begin
		rtt_result_t want;
		pkt_item_t   p;
		pkt_fire <= arst_n && pkt.valid && pkt.ready;
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if (pkt.valid && pkt.ready) begin
				p = '{pkt.ipv4_tcp, pkt.source_addr, pkt.dest_addr, pkt.syn_flag, pkt.ack_flag,
					pkt.sequence_number, pkt.ack_number, pkt.stamp_sec, pkt.stamp_usec};
				want = predict_rtt(p);
				expected_results.insert(expected_results.size(), want);
			end
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					$display("tb_top: result with nothing expected");
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (want.ev == EV_MEASURED) measured_count++;
					if (want.ev == EV_TABLE_FULL) full_count++;
					if (res.event_res !== want.ev)
						report_mismatch("event_res", 64'(res.event_res), 64'(want.ev));
					if (res.slot !== want.slot)
						report_mismatch("slot", 64'(res.slot), 64'(want.slot));
					if (res.sample_usec !== want.sample_usec)
						report_mismatch("sample_usec", 64'(res.sample_usec), 64'(want.sample_usec));
					if (res.total_usec !== want.total_usec)
						report_mismatch("total_usec", 64'(res.total_usec), 64'(want.total_usec));
					if (res.handshakes !== want.handshakes)
						report_mismatch("handshakes", 64'(res.handshakes), 64'(want.handshakes));
				end
				checked_count <= checked_count + 1;
			end
			if (cycle_count > CYCLE_LIMIT) begin
				$display("tb_top: cycle limit reached");
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	task automatic queue_handshake(bit proper);
		int          k;
		logic [31:0] s, d, sq, sec;
		logic [19:0] us;
		k = $urandom_range(pair_src.size() - 1, 0);
		s = pair_src[k];
		d = pair_dst[k];
		sq = ($urandom_range(7, 0) == 0) ? 32'hFFFF_FFFF : $urandom;
		sec = $urandom_range(1000, 0);
		us = 20'($urandom_range(999999, 0));
		queue_pkt(syn_pkt(s, d, sq, sec, us));
		if ($urandom_range(3, 0) == 0) queue_pkt(rand_pkt());
		if (proper)
			queue_pkt(synack_pkt(d, s, sq + 32'd1,
				($urandom_range(9, 0) == 0) ? sec - 1 : sec + $urandom_range(3, 0),
				20'($urandom_range(999999, 0))));
		else
			queue_pkt(synack_pkt(d, s, sq + 32'($urandom_range(3, 2)), sec, us));
	endtask

	initial begin
		int n;
		pkt_item_t p;
		pkt.valid = 1'b0;
		{pkt.ipv4_tcp, pkt.source_addr, pkt.dest_addr, pkt.syn_flag, pkt.ack_flag,
			pkt.sequence_number, pkt.ack_number, pkt.stamp_sec, pkt.stamp_usec} = '0;
		res.ready = 1'b0;
		tbl_used = 0;
		error_count = 0;
		cycle_count = 0;
		sent_count = 0;
		checked_count = 0;
		measured_count = 0;
		full_count = 0;
		hold_sender = 1'b1;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n = 1'b1;

		// Directed: ignored forms, extremes, rearm, negative delta, wrap of sequence.
		p = rand_pkt(); p.ipv4_tcp = 0; p.syn_flag = 1; queue_pkt(p);
		p = rand_pkt(); p.ipv4_tcp = 1; p.syn_flag = 0; queue_pkt(p);
		queue_pkt(synack_pkt(32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 20'h0));
		queue_pkt(syn_pkt(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 20'h0));
		queue_pkt(synack_pkt(32'h0, 32'hFFFF_FFFF, 32'h5, 32'h0, 20'h0));
		queue_pkt(synack_pkt(32'h0, 32'hFFFF_FFFF, 32'h0,
			32'hFFFF_FFFF, 20'hFFFFF));
		queue_pkt(synack_pkt(32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 20'h0));
		queue_pkt(syn_pkt(32'hFFFF_FFFF, 32'h0, 32'h10, 32'h100, 20'd5));
		queue_pkt(syn_pkt(32'hFFFF_FFFF, 32'h0, 32'h20, 32'h100, 20'd9));
		queue_pkt(synack_pkt(32'h0, 32'hFFFF_FFFF, 32'h21, 32'hFF, 20'd999999));
		queue_pkt(syn_pkt(32'h0, 32'hFFFF_FFFF, 32'h1, 32'h0, 20'hFFFFF));
		queue_pkt(synack_pkt(32'hFFFF_FFFF, 32'h0, 32'h2,
			32'hFFFF_FFFF, 20'hFFFFF));
		queue_pkt(syn_pkt(32'h0, 32'hFFFF_FFFF, 32'h7, 32'h0, 20'h0));
		queue_pkt(synack_pkt(32'hFFFF_FFFF, 32'h0, 32'h8, 32'h0, 20'h0));
		add_pair(32'hFFFF_FFFF, 32'h0);
		add_pair(32'h0, 32'hFFFF_FFFF);
		hold_sender = 1'b0;

		// Random: mostly handshakes on a growing pair set, then table full.
		n = 0;
		while (n < 830) begin
			if (n == 400) begin
				// Let all queued packets and expected results drain before continuing.
				wait (pending_pkts.size() == 0 && !pkt.valid);
				hold_sender = 1'b1;
				wait (expected_results.size() == 0);
				@(negedge clk);
				hold_sender = 1'b0;
			end
			if (pair_src.size() < 70 && $urandom_range(3, 0) == 0) begin
				add_pair($urandom, $urandom);
			end
			case ($urandom_range(9, 0))
				0, 1: begin
					queue_pkt(rand_pkt());
					n++;
				end
				2: begin
					queue_handshake(1'b0);
					n += 2;
				end
				default: begin
					queue_handshake(1'b1);
					n += 2;
				end
			endcase
			if (pending_pkts.size() > 40) wait (pending_pkts.size() < 10);
		end
		wait (pending_pkts.size() == 0 && !pkt.valid);
		wait (expected_results.size() == 0);
		repeat (20) @(posedge clk);
		$display("tb_top: %0d packets sent, %0d results checked, %0d measured, %0d table full",
			sent_count, checked_count, measured_count, full_count);
		$display("tb_top: table entries used %0d of %0d", tbl_used, TABLE_ENTRIES);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end
endmodule
